// ===== sv/deq_pkg.sv =====
// Shared constants and types for the double-ended queue core.
package deq_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int SUM_W       = CNT_W + 1;

  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_QUERY      = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } deq_state_t;

  // Store access and result info produced for one request.
  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [ADDR_W-1:0]      rd_front_addr;
    logic [ADDR_W-1:0]      rd_back_addr;
    logic [CNT_W-1:0]       count;
    logic [1:0]             status;
  } deq_access_t;

endpackage

// ===== sv/double_ended_queue_core.sv =====
// Top level of the double-ended queue core: request FSM, entry store and result register.
//
// Bounded deque of CAPACITY entries held in a ring in two identical copies of a
// one-write/one-read RAM, so that the front and back entries can be read in the
// same cycle. A request is taken in the cycle the core is idle: the push, if any,
// is written and both end slots after the request are read in that cycle; in
// ST_RESP a same-slot push is forwarded around the RAM read, and the result
// register is loaded once it is free, which may wait on out_ready. Store entries
// need no clearing after reset: only entries written by a push ever reach the
// outputs, since an empty result carries zeros.
module double_ended_queue_core import deq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_front_value,
  output logic signed [31:0] out_back_value,
  output logic [4:0]         out_entry_count,
  output logic               out_is_empty,
  output logic [1:0]         out_status
);

  deq_state_t             state_r, state_nxt;
  deq_access_t            acc;
  logic                   in_fire, out_load;
  logic [VALUE_WIDTH-1:0] rd_front, rd_back;

  logic                   fwd_front_r, fwd_back_r;
  logic [VALUE_WIDTH-1:0] wdata_r;
  logic [CNT_W-1:0]       pend_count_r;
  logic [1:0]             pend_status_r;

  logic                   out_valid_r;
  logic [31:0]            front_r, back_r;
  logic [4:0]             count_out_r;
  logic                   empty_out_r;
  logic [1:0]             status_out_r;

  logic [VALUE_WIDTH-1:0] front_sel, back_sel;
  logic [63:0]            front_ext, back_ext;
  logic                   pend_empty;

  assign in_fire = in_valid && in_ready;

  deq_ptr u_ptr (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_fire (in_fire),
    .mode     (in_mode),
    .value    (in_value),
    .acc      (acc)
  );

  deq_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_ram_front (
    .clk     (clk),
    .we      (in_fire && acc.we),
    .wr_addr (acc.wr_addr),
    .wr_data (acc.wr_data),
    .rd_en   (in_fire),
    .rd_addr (acc.rd_front_addr),
    .rd_data (rd_front)
  );

  deq_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_ram_back (
    .clk     (clk),
    .we      (in_fire && acc.we),
    .wr_addr (acc.wr_addr),
    .wr_data (acc.wr_data),
    .rd_en   (in_fire),
    .rd_addr (acc.rd_back_addr),
    .rd_data (rd_back)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_RESP;
      ST_RESP: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_RESP: out_load = !out_valid_r || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // RAM reads return old data when the same slot is written in that cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_front_r   <= acc.we && (acc.rd_front_addr == acc.wr_addr);
      fwd_back_r    <= acc.we && (acc.rd_back_addr == acc.wr_addr);
      wdata_r       <= acc.wr_data;
      pend_count_r  <= acc.count;
      pend_status_r <= acc.status;
    end
  end

  assign front_sel  = fwd_front_r ? wdata_r : rd_front;
  assign back_sel   = fwd_back_r ? wdata_r : rd_back;
  assign front_ext  = 64'(front_sel);
  assign back_ext   = 64'(back_sel);
  assign pend_empty = (pend_count_r == '0);

  always_ff @(posedge clk) begin
    if (out_load) begin
      front_r      <= pend_empty ? 32'd0 : front_ext[31:0];
      back_r       <= pend_empty ? 32'd0 : back_ext[31:0];
      count_out_r  <= 5'(pend_count_r);
      empty_out_r  <= pend_empty;
      status_out_r <= pend_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_front_value = $signed(front_r);
  assign out_back_value  = $signed(back_r);
  assign out_entry_count = count_out_r;
  assign out_is_empty    = empty_out_r;
  assign out_status      = status_out_r;

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready && state_r == ST_RESP)
    else $error("second request taken while one is pending");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_front_value == 0 && out_back_value == 0)
    else $error("empty result carries nonzero values");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_is_empty == (out_entry_count == 5'd0))
    else $error("empty flag disagrees with count");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_FULL |-> out_entry_count == 5'(CAPACITY))
    else $error("push dropped while not full");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_EMPTY |-> out_is_empty)
    else $error("pop ignored while not empty");
`endif

endmodule

// ===== sv/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/deq_ptr.sv =====
// Head pointer and fill count, with the store addresses for each request.
module deq_ptr import deq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_fire,
  input  logic [2:0]  mode,
  input  logic [31:0] value,
  output deq_access_t acc
);

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] head_dec, head_inc, tail_slot, back_slot;
  logic              full, empty;
  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic [1:0]        status;

  function automatic logic [ADDR_W-1:0] wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= SUM_W'(CAPACITY)) ? s - SUM_W'(CAPACITY) : s;
    return r[ADDR_W-1:0];
  endfunction

  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign head_dec  = (head_r == '0) ? ADDR_W'(CAPACITY - 1) : head_r - ADDR_W'(1);
  assign head_inc  = (head_r == ADDR_W'(CAPACITY - 1)) ? '0 : head_r + ADDR_W'(1);
  assign tail_slot = wrap(SUM_W'(head_r) + SUM_W'(count_r));

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    we        = 1'b0;
    wr_addr   = tail_slot;
    status    = STATUS_OK;
    case (mode)
      MODE_PUSH_FRONT: begin
        if (full) begin
          status = STATUS_FULL;
        end else begin
          head_nxt  = head_dec;
          wr_addr   = head_dec;
          we        = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          status = STATUS_FULL;
        end else begin
          we        = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status = STATUS_EMPTY;
        end else begin
          head_nxt  = head_inc;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          status = STATUS_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        // query, and the unused codes, change nothing
      end
    endcase
  end

  // back slot after the request; don't care when the queue ends up empty
  always_comb begin
    if (count_nxt == '0) begin
      back_slot = head_nxt;
    end else begin
      back_slot = wrap(SUM_W'(head_nxt) + SUM_W'(count_nxt) - SUM_W'(1));
    end
  end

  always_comb begin
    acc.we            = we;
    acc.wr_addr       = wr_addr;
    acc.wr_data       = VALUE_WIDTH'($unsigned(value));
    acc.rd_front_addr = head_nxt;
    acc.rd_back_addr  = back_slot;
    acc.count         = count_nxt;
    acc.status        = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (req_fire) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SUM_W'(head_r) < SUM_W'(CAPACITY))
    else $error("head index beyond capacity");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !req_fire |=> $stable(head_r) && $stable(count_r))
    else $error("pointer moved without a request");
`endif

endmodule
